// ===== rtl/mts_pkg.sv =====
`timescale 1ns / 1ps
package mts_pkg;
  localparam int MAX_TASKS = 16;
  localparam logic [1:0] CLS_RT = 2'd0;
  localparam logic [1:0] CLS_IA = 2'd1;
  localparam logic [1:0] CLS_BA = 2'd2;
  localparam logic [1:0] CFG_QUANTUM = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_TASK_COUNT = 2'd2;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_RR, ST_UPDATE, ST_COUNT, ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
    logic [7:0]  age;
    logic        done;
  } entry_t;
endpackage

// ===== rtl/mts_cell.sv =====
`timescale 1ns / 1ps
// One table entry; shifts its contents to the neighbor when rotating.
module mts_cell
  import mts_pkg::*;
(
  input  logic   clk,
  input  logic   shift,
  input  logic   ld,
  input  entry_t ld_entry,
  input  entry_t prev,
  output entry_t cur
);
  entry_t e_r;
  always_ff @(posedge clk) begin
    if (ld) e_r <= ld_entry;
    else if (shift) e_r <= prev;
  end
  assign cur = e_r;
endmodule

// ===== rtl/multilevel_tick_scheduler.sv =====
`timescale 1ns / 1ps
// Channel | dir | handshake       | payload
// in_     | in  | in_valid/stall  | command slot task_class arrival burst prio
// out_    | out | out_valid/stall | served..all_done
// cfg_    | in  | cfg_valid/ready | cfg_index cfg_data
// A load is written the cycle after it is accepted; no item is taken while it is pending.
// A tick walks the ring of MAX_TASKS cells four times (age+select, round robin,
// update, recount; the round-robin walk is skipped when a real-time entry wins)
// and then passes ST_OUT, where the result is registered and out_valid rises.
// Reset is synchronous; tables are not cleared.
// A result waits in the output register; the next item is not taken until it leaves.
module multilevel_tick_scheduler
  import mts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [3:0]  in_slot,
  input  logic [1:0]  in_task_class,
  input  logic [15:0] in_arrival,
  input  logic [15:0] in_burst,
  input  logic [7:0]  in_prio,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_served,
  output logic [3:0]  out_served_slot,
  output logic [1:0]  out_served_class,
  output logic        out_finished,
  output logic [15:0] out_fin_tick,
  output logic [15:0] out_turnaround,
  output logic [15:0] out_waiting,
  output logic        out_all_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  state_t state_r, state_nxt;
  logic [3:0]  quantum_r;
  logic [7:0]  thr_r;
  logic [4:0]  tcount_r;
  logic [15:0] now_r;
  logic [IW-1:0] rr_r, head_r, sel_r;
  logic [3:0]  slice_r;
  logic [CW-1:0] cnt_r, ncnt_r;
  logic        found_r, rt_r;
  logic [1:0]  fcls_r;
  logic [15:0] best_r;
  logic [IW-1:0] start_r;
  logic [CW-1:0] step_r;
  logic ld_pend_r;

  entry_t cells [MAX_TASKS];
  entry_t ld_e, tail_new;
  logic [MAX_TASKS-1:0] ld_v;
  logic shift;

  logic [CW-1:0] n_c;
  assign n_c = ({1'b0, tcount_r} > 6'(MAX_TASKS)) ? CW'(MAX_TASKS) : CW'(tcount_r);

  // cells[0] is the head; rotating moves cell i+1 into i, head into tail
  genvar g;
  for (g = 0; g < MAX_TASKS; g++) begin : g_cell
    mts_cell u_cell (
      .clk(clk), .shift(shift), .ld(ld_v[g]), .ld_entry(ld_e),
      .prev(g == MAX_TASKS - 1 ? tail_new : cells[(g + 1) % MAX_TASKS]),
      .cur(cells[g])
    );
  end

  entry_t h;
  logic [IW-1:0] hidx;
  logic in_use, elig;
  logic [7:0] thr_c;
  logic [3:0] q_c;
  logic [8:0] age_inc;
  assign h = cells[0];
  assign hidx = head_r;
  assign in_use = {1'b0, hidx} < CW'(n_c);
  assign elig = !h.done && h.arrival <= now_r;
  assign thr_c = thr_r == 8'd0 ? 8'd1 : thr_r;
  assign q_c = quantum_r == 4'd0 ? 4'd1 : quantum_r;
  assign age_inc = {1'b0, h.age} + 9'd1;

  logic [15:0] now_inc;
  assign now_inc = now_r == 16'hFFFF ? now_r : now_r + 16'd1;

  logic [15:0] rem_dec, tat_c, wait_c;
  assign rem_dec = h.remaining == 16'd0 ? 16'd0 : h.remaining - 16'd1;
  assign tat_c = now_inc >= h.arrival ? now_inc - h.arrival : 16'd0;
  assign wait_c = tat_c >= h.burst ? tat_c - h.burst : 16'd0;

  logic acc;
  assign acc = in_valid && !in_stall;
  assign in_stall = state_r != ST_IDLE || out_valid || ld_pend_r;
  assign cfg_ready = state_r == ST_IDLE;

  logic [3:0] ld_slot_r;
  entry_t ld_r;
  logic sel_now, rr_hit;
  logic [IW:0] rel;
  always_comb begin
    rel = {1'b0, hidx} - {1'b0, start_r};
    if (hidx < start_r) rel = rel + (IW+1)'(n_c);
  end

  always_comb begin
    state_nxt = state_r;
    shift = 1'b0;
    tail_new = h;
    ld_v = '0;
    ld_e = ld_r;
    sel_now = 1'b0;
    rr_hit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (ld_pend_r) begin
          for (int i = 0; i < MAX_TASKS; i++)
            if ({28'd0, ld_slot_r} == i) ld_v[i] = 1'b1;
        end else if (acc && in_command == CMD_TICK) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        shift = 1'b1;
        if (in_use && elig && h.remaining != 16'd0) begin
          if (age_inc[7:0] >= thr_c || age_inc[8]) begin
            tail_new.age = 8'd0;
            if (h.prio > 8'd1) tail_new.prio = h.prio - 8'd1;
          end else tail_new.age = age_inc[7:0];
        end
        if (in_use && elig) begin
          if (h.cls == CLS_RT && (!found_r || !rt_r || {8'd0, tail_new.prio} < best_r))
            sel_now = 1'b1;
          else if (h.cls == CLS_BA && !rt_r && (!found_r || h.remaining < best_r))
            sel_now = 1'b1;
        end
        if (step_r == CW'(MAX_TASKS - 1))
          state_nxt = (rt_r || (sel_now && h.cls == CLS_RT)) ? ST_UPDATE : ST_RR;
      end
      ST_RR: begin
        shift = 1'b1;
        if (in_use && elig && h.cls == CLS_IA && rel < (IW+1)'(cnt_r)) rr_hit = 1'b1;
        if (step_r == CW'(MAX_TASKS - 1)) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        shift = 1'b1;
        if (found_r && hidx == sel_r) begin
          tail_new.age = 8'd0;
          tail_new.remaining = rem_dec;
          if (rem_dec == 16'd0) tail_new.done = 1'b1;
        end
        if (step_r == CW'(MAX_TASKS - 1)) state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        shift = 1'b1;
        if (step_r == CW'(MAX_TASKS - 1)) state_nxt = ST_OUT;
      end
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      quantum_r <= 4'd3;
      thr_r <= 8'd10;
      tcount_r <= 5'd1;
      now_r <= '0;
      rr_r <= '0;
      head_r <= '0;
      slice_r <= '0;
      out_valid <= 1'b0;
      ld_pend_r <= 1'b0;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_QUANTUM: quantum_r <= cfg_data[3:0];
          CFG_THRESHOLD: thr_r <= cfg_data;
          CFG_TASK_COUNT: tcount_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      ld_pend_r <= 1'b0;
      if (state_r == ST_IDLE && acc && in_command == CMD_LOAD &&
          {1'b0, in_slot} < 5'(MAX_TASKS))
        ld_pend_r <= 1'b1;
      if (shift) begin
        head_r <= head_r == IW'(MAX_TASKS - 1) ? '0 : head_r + 1'b1;
        step_r <= step_r == CW'(MAX_TASKS - 1) ? '0 : step_r + 1'b1;
      end
      if (state_r == ST_IDLE && state_nxt == ST_SCAN) begin
        found_r <= 1'b0; rt_r <= 1'b0; step_r <= '0;
        start_r <= rr_r;
        cnt_r <= n_c;
      end
      // round-robin start reduced modulo n while the first walk runs
      if (state_r == ST_SCAN && n_c != '0 && {1'b0, start_r} >= n_c)
        start_r <= IW'({1'b0, start_r} - n_c);
      if (sel_now) begin
        found_r <= 1'b1; sel_r <= hidx; fcls_r <= h.cls;
        rt_r <= h.cls == CLS_RT;
        best_r <= h.cls == CLS_RT ? {8'd0, tail_new.prio} : h.remaining;
      end
      if (state_r == ST_SCAN && state_nxt == ST_RR) begin
        if (n_c != '0) begin
          found_r <= 1'b0; cnt_r <= n_c;
        end else cnt_r <= '0;
        sel_r <= sel_now ? hidx : (found_r ? sel_r : '0);
        best_r <= {15'd0, found_r || sel_now};
        fcls_r <= sel_now ? h.cls : (found_r ? fcls_r : CLS_RT);
      end
      if (rr_hit) begin
        found_r <= 1'b1; sel_r <= hidx; fcls_r <= CLS_IA;
        cnt_r <= CW'(rel);
        rt_r <= h.remaining <= 16'd1;
      end
      if (state_r == ST_RR && state_nxt == ST_UPDATE && !found_r && !rr_hit && best_r[0])
        found_r <= 1'b1;
      if (state_r == ST_UPDATE) begin
        if (step_r == '0) begin
          out_finished <= 1'b0; out_fin_tick <= '0;
          out_turnaround <= '0; out_waiting <= '0;
          ncnt_r <= '0;
          if (found_r && fcls_r == CLS_IA) begin
            if (rt_r || slice_r + 4'd1 >= q_c) begin
              slice_r <= '0;
              rr_r <= {1'b0, sel_r} + 1'b1 >= (IW+1)'(n_c) ? '0 : sel_r + 1'b1;
            end else slice_r <= slice_r + 4'd1;
          end
        end
        if (found_r && hidx == sel_r && rem_dec == 16'd0) begin
          out_finished <= 1'b1; out_fin_tick <= now_inc;
          out_turnaround <= tat_c; out_waiting <= wait_c;
        end
      end
      if (state_r == ST_COUNT && in_use && h.done) ncnt_r <= ncnt_r + 1'b1;
      if (state_r == ST_OUT) begin
        now_r <= now_inc;
        out_valid <= 1'b1;
        out_served <= found_r;
        out_served_slot <= found_r ? 4'(sel_r) : 4'd0;
        out_served_class <= found_r ? fcls_r : CLS_RT;
        out_all_done <= ncnt_r == n_c;
      end
    end
    if (state_r == ST_IDLE && acc) begin
      ld_slot_r <= in_slot;
      ld_r.cls <= in_task_class; ld_r.arrival <= in_arrival;
      ld_r.burst <= in_burst; ld_r.remaining <= in_burst;
      ld_r.prio <= in_prio; ld_r.age <= '0; ld_r.done <= 1'b0;
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall) else $error("input taken while busy");
  a_head_home: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> head_r == '0) else $error("ring not realigned");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |=> out_valid) else $error("result lost");
endmodule

// ===== bench/multilevel_tick_scheduler_tb.sv =====
`timescale 1ns / 1ps
module multilevel_tick_scheduler_tb;
  import mts_pkg::*;

  localparam int SLOTS = 16;
  localparam int SETTLE_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic        command;
    logic [3:0]  slot;
    logic [1:0]  cls;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } task_item_t;

  typedef struct {
    logic        served;
    logic [3:0]  slot;
    logic [1:0]  cls;
    logic        finished;
    logic [15:0] fin_tick;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;
  } tick_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic [3:0] in_slot = '0;
  logic [1:0] in_task_class = '0;
  logic [15:0] in_arrival = '0;
  logic [15:0] in_burst = '0;
  logic [7:0] in_prio = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_served;
  logic [3:0] out_served_slot;
  logic [1:0] out_served_class;
  logic out_finished;
  logic [15:0] out_fin_tick;
  logic [15:0] out_turnaround;
  logic [15:0] out_waiting;
  logic out_all_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  task_item_t pending_q[$];
  tick_report_t report_q[$];
  task_item_t cur_item;

  int errors = 0;
  int quiet_cycles = 0;
  bit idle_en = 1'b0;
  bit hold_req = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_left = 0;

  // scheduler shadow state
  int quantum_r, threshold_r, task_count_r;
  int sim_now, rr_ptr, slice_cnt;
  logic [1:0] e_cls[SLOTS];
  logic [15:0] e_arr[SLOTS];
  logic [15:0] e_burst[SLOTS];
  logic [15:0] e_rem[SLOTS];
  logic [7:0] e_prio[SLOTS];
  logic [7:0] e_age[SLOTS];
  bit e_done[SLOTS];

  multilevel_tick_scheduler u_top (.*);

  always #10 clk = ~clk;

  function automatic bit ready_to_run(int i);
    return !e_done[i] && int'(e_arr[i]) <= sim_now;
  endfunction

  function automatic void reset_shadow();
    quantum_r = 3;
    threshold_r = 10;
    task_count_r = 1;
    sim_now = 0;
    rr_ptr = 0;
    slice_cnt = 0;
    for (int i = 0; i < SLOTS; i++) begin
      e_cls[i] = '0; e_arr[i] = '0; e_burst[i] = '0; e_rem[i] = '0;
      e_prio[i] = '0; e_age[i] = '0; e_done[i] = 1'b0;
    end
  endfunction

  function automatic void schedule_item(task_item_t it);
    int n, thr, q, sel, best, a, idx, start, done_cnt;
    bit found;
    tick_report_t r;
    if (it.command == CMD_LOAD) begin
      e_cls[it.slot] = it.cls;
      e_arr[it.slot] = it.arrival;
      e_burst[it.slot] = it.burst;
      e_rem[it.slot] = it.burst;
      e_prio[it.slot] = it.prio;
      e_age[it.slot] = '0;
      e_done[it.slot] = 1'b0;
      return;
    end
    n = task_count_r > SLOTS ? SLOTS : task_count_r;
    thr = threshold_r == 0 ? 1 : threshold_r;
    q = quantum_r == 0 ? 1 : quantum_r;
    found = 1'b0;
    sel = 0;
    best = 0;
    r = '{default: '0};
    for (int i = 0; i < n; i++) begin
      if (ready_to_run(i) && e_rem[i] > 0) begin
        a = int'(e_age[i]) + 1;
        if (a >= thr) begin
          a = 0;
          if (e_prio[i] > 1) e_prio[i] = e_prio[i] - 1;
        end
        e_age[i] = a[7:0];
      end
    end
    for (int i = 0; i < n; i++) begin
      if (ready_to_run(i) && e_cls[i] == CLS_RT && (!found || int'(e_prio[i]) < best)) begin
        found = 1'b1; best = e_prio[i]; sel = i;
      end
    end
    if (!found && n > 0) begin
      start = rr_ptr % n;
      for (int k = 0; k < n; k++) begin
        idx = (start + k) % n;
        if (!found && ready_to_run(idx) && e_cls[idx] == CLS_IA) begin
          found = 1'b1;
          sel = idx;
          slice_cnt++;
          if (e_rem[idx] <= 1 || slice_cnt >= q) begin
            slice_cnt = 0;
            rr_ptr = (idx + 1) % n;
          end
        end
      end
    end
    if (!found) begin
      for (int i = 0; i < n; i++) begin
        if (ready_to_run(i) && e_cls[i] == CLS_BA && (!found || int'(e_rem[i]) < best)) begin
          found = 1'b1; best = e_rem[i]; sel = i;
        end
      end
    end
    if (sim_now < 65535) sim_now++;
    if (found) begin
      e_age[sel] = '0;
      if (e_rem[sel] > 0) e_rem[sel] = e_rem[sel] - 1;
      r.served = 1'b1;
      r.slot = sel[3:0];
      r.cls = e_cls[sel];
      if (e_rem[sel] == 0) begin
        e_done[sel] = 1'b1;
        r.finished = 1'b1;
        r.fin_tick = sim_now[15:0];
        a = sim_now >= int'(e_arr[sel]) ? sim_now - int'(e_arr[sel]) : 0;
        r.turnaround = a[15:0];
        a = a >= int'(e_burst[sel]) ? a - int'(e_burst[sel]) : 0;
        r.waiting = a[15:0];
      end
    end
    done_cnt = 0;
    for (int i = 0; i < n; i++) if (e_done[i]) done_cnt++;
    r.all_done = done_cnt == n;
    report_q.push_back(r);
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_valid && !in_stall) schedule_item(cur_item);
    if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (in_valid && idle_en && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0 && rst_n) begin
        cur_item = pending_q.pop_front();
        in_command <= cur_item.command;
        in_slot <= cur_item.slot;
        in_task_class <= cur_item.cls;
        in_arrival <= cur_item.arrival;
        in_burst <= cur_item.burst;
        in_prio <= cur_item.prio;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and result-side stall
  always @(posedge clk) begin
    tick_report_t r;
    bit stall_next;
    if (out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected transaction expected none actual slot %0d", $time,
                 out_served_slot);
        errors++;
      end else begin
        r = report_q.pop_front();
        check_field("served", r.served, out_served);
        check_field("served_slot", r.slot, out_served_slot);
        check_field("served_class", r.cls, out_served_class);
        check_field("finished", r.finished, out_finished);
        check_field("fin_tick", r.fin_tick, out_fin_tick);
        check_field("turnaround", r.turnaround, out_turnaround);
        check_field("waiting", r.waiting, out_waiting);
        check_field("all_done", r.all_done, out_all_done);
      end
    end
    stall_next = 1'b0;
    if (hold_req && hold_left == 0) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      stall_next = 1'b1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 14);
      stall_next = 1'b1;
    end
    out_stall <= stall_next;
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_index <= idx;
    cfg_data <= value[7:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_QUANTUM: quantum_r = value & 'hF;
      CFG_THRESHOLD: threshold_r = value & 'hFF;
      CFG_TASK_COUNT: task_count_r = value & 'h1F;
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(posedge clk); while (pending_q.size() > 0 || in_valid || report_q.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_load(int slot, logic [1:0] cls, int arrival, int burst, int prio);
    task_item_t it;
    it.command = CMD_LOAD;
    it.slot = slot[3:0];
    it.cls = cls;
    it.arrival = arrival[15:0];
    it.burst = burst[15:0];
    it.prio = prio[7:0];
    pending_q.push_back(it);
  endtask

  task automatic push_tick();
    task_item_t it;
    it.command = CMD_TICK;
    it.slot = 4'($urandom);
    it.cls = 2'($urandom);
    it.arrival = 16'($urandom);
    it.burst = 16'($urandom);
    it.prio = 8'($urandom);
    pending_q.push_back(it);
  endtask

  task automatic random_items(int count);
    int clock_est, lim, arr, bur, pick;
    logic [1:0] cls;
    clock_est = sim_now;
    lim = task_count_r > SLOTS ? SLOTS : (task_count_r == 0 ? SLOTS : task_count_r);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        push_tick();
        clock_est++;
      end else begin
        pick = $urandom_range(0, 19);
        cls = pick == 0 ? 2'd3 : 2'($urandom_range(0, 2));
        pick = $urandom_range(0, 19);
        arr = pick == 0 ? $urandom_range(0, 65535) : clock_est + $urandom_range(0, 20);
        if (arr > 65535) arr = 65535;
        pick = $urandom_range(0, 29);
        bur = pick == 0 ? 0 : (pick == 1 ? $urandom_range(1, 65535) : $urandom_range(1, 12));
        push_load($urandom_range(0, lim - 1), cls, arr, bur, $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    int qv[8] = '{3, 15, 0, 1, 7, 2, 15, 4};
    int tv[8] = '{10, 255, 0, 1, 2, 5, 3, 128};
    int cv[8] = '{1, 16, 31, 0, 17, 8, 16, 12};
    reset_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every slot written before any tick can reach it
    push_load(0, CLS_RT, 0, 0, 0);
    push_load(1, CLS_IA, 0, 65535, 255);
    push_load(2, CLS_BA, 65535, 1, 128);
    push_load(3, 2'd3, 0, 5, 7);
    push_load(4, CLS_RT, 1, 3, 200);
    push_load(5, CLS_RT, 0, 2, 200);
    push_load(6, CLS_IA, 0, 2, 1);
    push_load(7, CLS_IA, 2, 4, 9);
    push_load(8, CLS_BA, 0, 6, 3);
    push_load(9, CLS_BA, 0, 2, 3);
    push_load(10, CLS_BA, 3, 0, 255);
    push_load(11, CLS_IA, 0, 1, 0);
    push_load(12, CLS_RT, 5, 1, 1);
    push_load(13, CLS_BA, 4, 3, 50);
    push_load(14, CLS_IA, 1, 7, 60);
    push_load(15, CLS_RT, 40000, 9, 255);
    repeat (3) push_tick();
    drain();
    write_reg(CFG_TASK_COUNT, 16);
    repeat (5) push_tick();
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_QUANTUM, qv[p]);
      write_reg(CFG_THRESHOLD, tv[p]);
      write_reg(CFG_TASK_COUNT, cv[p]);
      idle_en = p != 7 && (p % 3 != 2);
      random_items(125);
      if (p == 4) hold_req = 1'b1;
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mts_pkg.sv
rtl/mts_cell.sv
rtl/multilevel_tick_scheduler.sv
bench/multilevel_tick_scheduler_tb.sv
